>>> rtl/boot_info_framebuffer_tag_parser_assert.svh
// Assertion helpers shared by the parser modules.
`ifndef BOOT_INFO_FRAMEBUFFER_TAG_PARSER_ASSERT_SVH
`define BOOT_INFO_FRAMEBUFFER_TAG_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BIFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bift assertion failed");

// Next-cycle implication.
`define BIFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bift assertion failed");

`endif

>>> rtl/bift_pkg.sv
package bift_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] fb_base;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] pitch;
		logic [7:0]  depth_bits;
	} result_t;

	localparam logic [31:0] BOOT_MAGIC  = 32'h36D7_6289;
	localparam logic [31:0] HDR_BYTES   = 32'd8;
	localparam logic [31:0] FB_MIN_SIZE = 32'd32;
	localparam logic [31:0] MIN_SIZE    = 32'd16;
	localparam logic [31:0] KIND_END    = 32'd0;
	localparam logic [31:0] KIND_FB     = 32'd8;
	localparam logic [7:0]  MIN_DEPTH   = 8'd8;

	localparam logic [1:0] ST_FOUND      = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
	localparam logic [1:0] ST_NO_FB      = 2'd2;
	localparam logic [1:0] ST_STREAM_END = 2'd3;

endpackage

>>> rtl/bift_front.sv
`include "boot_info_framebuffer_tag_parser_assert.svh"

module bift_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  bift_pkg::byte_item_t item,
	output logic                 dec_push,
	output bift_pkg::result_t    dec
);
	import bift_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_INFO   = 3'd1;
	localparam logic [2:0] PH_TAGHDR = 3'd2;
	localparam logic [2:0] PH_FBBODY = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	localparam logic [4:0] CNT_MAGIC_END = 5'd3;
	localparam logic [4:0] CNT_INFO_END  = 5'd7;
	localparam logic [4:0] CNT_ADDR_END  = 5'd8;
	localparam logic [4:0] CNT_PITCH_END = 5'd12;
	localparam logic [4:0] CNT_WIDTH_END = 5'd16;
	localparam logic [4:0] CNT_HGT_END   = 5'd20;
	localparam logic [4:0] CNT_DEPTH     = 5'd20;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [31:0] pos_q, nts_q, nts_d;
	logic [31:0] lim_q, kind_q, len_q, size_q;
	logic [63:0] addr_q;
	logic [31:0] pitch_q, width_q, height_q;

	logic        proc, decide, live, fb_ok, adv_fail;
	logic [1:0]  status;
	logic [2:0]  ph;
	logic [4:0]  cnt;
	logic [31:0] pos, len_cur, len_sel, size_cur, magic_cur;
	logic [32:0] pad_sum;
	logic [33:0] nxt;

	assign proc      = take && (item.first || phase_q != PH_IDLE);
	assign ph        = item.first ? PH_INFO : phase_q;
	assign cnt       = item.first ? 5'd0 : cnt_q;
	assign pos       = item.first ? 32'd0 : pos_q;
	assign len_cur   = {item.data_byte, len_q[23:0]};
	assign size_cur  = {item.data_byte, size_q[23:0]};
	assign magic_cur = {item.data_byte, kind_q[23:0]};
	assign len_sel   = (ph == PH_TAGHDR) ? len_cur : len_q;
	// next tag offset, padded to 8 bytes; fits if nxt + 8 <= size
	assign pad_sum   = {1'b0, len_sel} + 33'd7;
	assign nxt       = {2'b00, nts_q} + {1'b0, pad_sum[32:3], 3'b000};
	assign adv_fail  = (nxt[33:32] != 2'b00) || (nxt[31:0] > lim_q);
	assign fb_ok     = (addr_q != 64'd0) && (width_q != 32'd0) && (height_q != 32'd0)
		&& (item.data_byte >= MIN_DEPTH);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt + 5'd1;
		nts_d   = nts_q;
		decide  = 1'b0;
		live    = 1'b1;
		status  = ST_FOUND;
		unique case (ph)
			PH_INFO: begin
				if (cnt == CNT_MAGIC_END && magic_cur != BOOT_MAGIC) begin
					decide = 1'b1;
					status = ST_BAD_MAGIC;
				end else if (cnt == CNT_INFO_END) begin
					if (size_cur < MIN_SIZE) begin
						decide = 1'b1;
						status = ST_NO_FB;
					end else begin
						phase_d = PH_TAGHDR;
						cnt_d   = 5'd0;
						nts_d   = HDR_BYTES;
					end
				end else begin
					phase_d = PH_INFO;
				end
			end
			PH_TAGHDR: begin
				if (cnt[2:0] == 3'd7) begin
					if (kind_q == KIND_END || len_cur < HDR_BYTES) begin
						decide = 1'b1;
						status = ST_NO_FB;
					end else if (kind_q == KIND_FB && len_cur >= FB_MIN_SIZE) begin
						phase_d = PH_FBBODY;
						cnt_d   = 5'd0;
					end else if (adv_fail) begin
						decide = 1'b1;
						status = ST_NO_FB;
					end else begin
						nts_d   = nxt[31:0];
						cnt_d   = 5'd0;
						phase_d = (len_cur == HDR_BYTES) ? PH_TAGHDR : PH_SKIP;
					end
				end
			end
			PH_FBBODY: begin
				if (cnt == CNT_DEPTH) begin
					if (fb_ok) begin
						decide = 1'b1;
						status = ST_FOUND;
					end else if (adv_fail) begin
						decide = 1'b1;
						status = ST_NO_FB;
					end else begin
						nts_d   = nxt[31:0];
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos + 32'd1 == nts_q) begin
					phase_d = PH_TAGHDR;
					cnt_d   = 5'd0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				live    = 1'b0;
			end
		endcase
		if (live && !decide && item.last) begin
			decide = 1'b1;
			status = ST_STREAM_END;
		end
		if (decide) begin
			phase_d = PH_IDLE;
		end
	end

	assign dec_push = proc && decide;

	always_comb begin
		dec        = '0;
		dec.status = status;
		if (status == ST_FOUND) begin
			dec.fb_base    = addr_q;
			dec.width      = width_q;
			dec.height     = height_q;
			dec.pitch      = pitch_q;
			dec.depth_bits = item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 5'd0;
			pos_q   <= 32'd0;
			nts_q   <= HDR_BYTES;
		end else if (proc) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos + 32'd1;
			nts_q   <= nts_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			case (ph)
				PH_INFO: begin
					if (!cnt[2]) begin
						kind_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end else begin
						size_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end
					if (cnt == CNT_INFO_END) begin
						lim_q <= size_cur - HDR_BYTES;
					end
				end
				PH_TAGHDR: begin
					if (!cnt[2]) begin
						kind_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end else begin
						len_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end
				end
				PH_FBBODY: begin
					if (cnt < CNT_ADDR_END) begin
						addr_q[{cnt[2:0], 3'b000} +: 8] <= item.data_byte;
					end else if (cnt < CNT_PITCH_END) begin
						pitch_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end else if (cnt < CNT_WIDTH_END) begin
						width_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end else if (cnt < CNT_HGT_END) begin
						height_q[{cnt[1:0], 3'b000} +: 8] <= item.data_byte;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`BIFT_ASSERT_IMP(a_tag_offset_aligned, clk, arst_n, phase_q != PH_IDLE, nts_q[2:0] == 3'b000)
	`BIFT_ASSERT_NXT(a_idle_after_result, clk, arst_n, dec_push, phase_q == PH_IDLE)
	`BIFT_ASSERT_IMP(a_skip_before_tag, clk, arst_n, phase_q == PH_SKIP, pos_q < nts_q)

endmodule

>>> rtl/bift_queue.sv
`include "boot_info_framebuffer_tag_parser_assert.svh"

module bift_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bift_pkg::result_t wdata,
	input  logic              pop,
	output bift_pkg::result_t rdata,
	output logic              empty,
	output logic              full
);
	import bift_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`BIFT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`BIFT_ASSERT_NXT(a_push_grows, clk, arst_n, push && !pop && !full, count_q == $past(count_q) + CW'(1))
	`BIFT_ASSERT_NXT(a_pop_shrinks, clk, arst_n, pop && !push && !empty, count_q == $past(count_q) - CW'(1))

endmodule

>>> rtl/bift_back.sv
module bift_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bift_pkg::result_t q_head,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output bift_pkg::result_t result
);
	import bift_pkg::*;

	logic        out_v_q;
	result_t     res_q;
	result_t     head_fix;
	logic [36:0] prod;
	logic [31:0] pitch_fix;

	// zero pitch: width * bytes per pixel
	assign prod      = {5'b0, q_head.width} * {32'b0, q_head.depth_bits[7:3]};
	assign pitch_fix = (q_head.pitch != 32'd0) ? q_head.pitch : prod[31:0];
	assign q_pop     = !q_empty && (!out_v_q || pop);
	assign empty     = !out_v_q;
	assign result    = res_q;

	always_comb begin
		head_fix       = q_head;
		head_fix.pitch = pitch_fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (q_pop) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= head_fix;
		end
	end

endmodule

>>> rtl/boot_info_framebuffer_tag_parser.sv
// Framebuffer tag parser for a boot information structure fed one byte per item.
// A byte with first set starts a structure; the parser checks the magic word, walks
// the tag list and delivers exactly one result per structure (found, bad magic, no
// usable framebuffer tag, or stream ended on the byte marked last). Bytes are accepted
// one per cycle while full is low; full rises only when QUEUE_DEPTH results
// are waiting in the queue between the parser and the output register. A result is
// written into the queue and then moves into the output register once that register
// is free. No clearing pass after reset.
module boot_info_framebuffer_tag_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  bift_pkg::byte_item_t byte_item,
	input  logic                 pop,
	output logic                 empty,
	output bift_pkg::result_t    result
);
	import bift_pkg::*;

	logic    take, dec_push, q_empty, q_full, q_pop;
	result_t dec, q_head;

	assign take = push && !q_full;
	assign full = q_full;

	bift_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (byte_item),
		.dec_push (dec_push),
		.dec      (dec)
	);

	bift_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dec_push),
		.wdata  (dec),
		.pop    (q_pop),
		.rdata  (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	bift_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
